// ----- rtl/c2d_pkg.sv -----
// shared types and constants for the convolution unit
package c2d_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_LOAD_PIXEL  = 2'd2,
    OP_COMPUTE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SATURATED = 2'd1,
    ST_BAD_COORD = 2'd2
  } status_e;

  localparam int unsigned REG_IN_CHANNELS  = 0;
  localparam int unsigned REG_FILT_COUNT   = 1;
  localparam int unsigned REG_KERN_SIDE    = 2;
  localparam int unsigned REG_IN_HEIGHT    = 3;
  localparam int unsigned REG_IN_WIDTH     = 4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  filter_index;
    logic [3:0]  channel_index;
    logic [4:0]  row_index;
    logic [4:0]  col_index;
    logic signed [15:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic [1:0]         status;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic start;     // latch item, perform load or start sum
    logic step;      // issue next tap read and accumulate
    logic finish;    // form the result
  } c2d_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_compute;
    logic bad_coord;
    logic last_tap;   // last tap read issued
    logic drained;    // last product accumulated
  } c2d_sts_t;

endpackage

// ----- rtl/c2d_stream_if.sv -----
// valid/ready channel carrying one payload
interface c2d_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/c2d_datapath.sv -----
// stores, address walk, multiply-accumulate and result formatting
module c2d_datapath #(
  parameter int unsigned MAX_IN_CH  = 16,
  parameter int unsigned MAX_OUT_CH = 16,
  parameter int unsigned MAX_KERNEL = 5,
  parameter int unsigned MAX_ROWS   = 32,
  parameter int unsigned MAX_COLS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  c2d_pkg::c2d_cmd_t  cmd_i,
  output c2d_pkg::c2d_sts_t  sts_o,
  input  c2d_pkg::in_item_t  item_i,
  input  logic [4:0]         in_channels_i,
  input  logic [4:0]         filt_count_i,
  input  logic [2:0]         kern_side_i,
  input  logic [5:0]         in_height_i,
  input  logic [5:0]         in_width_i,
  output c2d_pkg::out_item_t result_o
);
  import c2d_pkg::*;

  localparam int unsigned KK        = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned IMG_DEPTH = MAX_IN_CH * MAX_ROWS * MAX_COLS;
  localparam int unsigned WGT_DEPTH = MAX_OUT_CH * MAX_IN_CH * KK;
  localparam int unsigned IW = $clog2(IMG_DEPTH);
  localparam int unsigned WW = $clog2(WGT_DEPTH);
  localparam int unsigned BW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int unsigned CW = $clog2(MAX_IN_CH + 1);
  localparam int unsigned OW = $clog2(MAX_OUT_CH + 1);
  localparam int unsigned KW = $clog2(MAX_KERNEL + 1);
  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam int unsigned QW = $clog2(MAX_COLS + 1);
  localparam int unsigned AW = 48;

  logic [15:0] image_mem [IMG_DEPTH];
  logic [15:0] weight_mem [WGT_DEPTH];
  logic [15:0] bias_mem [MAX_OUT_CH];

  // clamped configuration values
  logic [CW-1:0] ic;
  logic [OW-1:0] oc;
  logic [KW-1:0] kk;
  logic [RW-1:0] hh;
  logic [QW-1:0] ww;

  always_comb begin
    ic = (in_channels_i == '0) ? CW'(1) :
         ({27'd0, in_channels_i} > MAX_IN_CH) ? CW'(MAX_IN_CH) : CW'(in_channels_i);
    oc = (filt_count_i == '0) ? OW'(1) :
         ({27'd0, filt_count_i} > MAX_OUT_CH) ? OW'(MAX_OUT_CH) : OW'(filt_count_i);
    kk = (kern_side_i == '0) ? KW'(1) :
         ({29'd0, kern_side_i} > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kern_side_i);
    hh = (in_height_i == '0) ? RW'(1) :
         ({26'd0, in_height_i} > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(in_height_i);
    ww = (in_width_i == '0) ? QW'(1) :
         ({26'd0, in_width_i} > MAX_COLS) ? QW'(MAX_COLS) : QW'(in_width_i);
  end

  in_item_t item_q;
  logic [7:0] ch_q, m_q, n_q;
  logic       rd_valid_q, prod_valid_q, last_rd_q, last_prod_q, drained_q;
  logic [15:0] px_q, wt_q;
  logic signed [31:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic [15:0] bias_q;

  // bad coordinate check on incoming item
  logic bad;
  always_comb begin
    bad = ({4'd0, item_i.filter_index} >= 8'(oc)) || (9'(kk) > 9'(hh)) ||
          (9'(kk) > 9'(ww)) ||
          ({4'd0, item_i.row_index} > 9'(hh) - 9'(kk)) ||
          ({4'd0, item_i.col_index} > 9'(ww) - 9'(kk));
  end

  // load and tap read addresses (products of constants only)
  logic [31:0] w_wr_addr, i_wr_addr, i_rd_addr, w_rd_addr;
  always_comb begin
    w_wr_addr = 32'(item_i.filter_index) * (MAX_IN_CH * KK) +
                32'(item_i.channel_index) * KK + 32'(item_i.row_index) * MAX_KERNEL +
                32'(item_i.col_index);
    i_wr_addr = 32'(item_i.channel_index) * (MAX_ROWS * MAX_COLS) +
                32'(item_i.row_index) * MAX_COLS + 32'(item_i.col_index);
    i_rd_addr = 32'(ch_q) * (MAX_ROWS * MAX_COLS) +
                (32'(item_q.row_index) + 32'(m_q)) * MAX_COLS +
                32'(item_q.col_index) + 32'(n_q);
    w_rd_addr = 32'(item_q.filter_index) * (MAX_IN_CH * KK) + 32'(ch_q) * KK +
                32'(m_q) * MAX_KERNEL + 32'(n_q);
  end

  // store writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      unique case (op_e'(item_i.operation))
        OP_LOAD_WEIGHT: if (32'(item_i.filter_index) < MAX_OUT_CH &&
                            32'(item_i.channel_index) < MAX_IN_CH &&
                            32'(item_i.row_index) < MAX_KERNEL &&
                            32'(item_i.col_index) < MAX_KERNEL)
          weight_mem[w_wr_addr[WW-1:0]] <= item_i.load_value;
        OP_LOAD_BIAS: if (32'(item_i.filter_index) < MAX_OUT_CH)
          bias_mem[item_i.filter_index[BW-1:0]] <= item_i.load_value;
        OP_LOAD_PIXEL: if (32'(item_i.channel_index) < MAX_IN_CH &&
                           32'(item_i.row_index) < MAX_ROWS &&
                           32'(item_i.col_index) < MAX_COLS)
          image_mem[i_wr_addr[IW-1:0]] <= item_i.load_value;
        default: ;
      endcase
    end
  end

  // registered store reads
  always_ff @(posedge clk_i) begin
    px_q <= image_mem[i_rd_addr[IW-1:0]];
    wt_q <= weight_mem[w_rd_addr[WW-1:0]];
    bias_q <= bias_mem[item_i.filter_index[BW-1:0]];
  end

  logic tap_last;
  assign tap_last = (ch_q == 8'(ic) - 8'd1) && (m_q == 8'(kk) - 8'd1) &&
                    (n_q == 8'(kk) - 8'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
      last_rd_q    <= 1'b0;
      last_prod_q  <= 1'b0;
      drained_q    <= 1'b0;
      ch_q <= '0;
      m_q  <= '0;
      n_q  <= '0;
    end else begin
      rd_valid_q   <= cmd_i.step;
      last_rd_q    <= cmd_i.step && tap_last;
      prod_valid_q <= rd_valid_q;
      last_prod_q  <= last_rd_q;
      drained_q    <= last_prod_q;
      if (cmd_i.start) begin
        ch_q <= '0;
        m_q  <= '0;
        n_q  <= '0;
      end else if (cmd_i.step) begin
        if (n_q != 8'(kk) - 8'd1) begin
          n_q <= n_q + 8'd1;
        end else begin
          n_q <= '0;
          if (m_q != 8'(kk) - 8'd1) begin
            m_q <= m_q + 8'd1;
          end else begin
            m_q  <= '0;
            ch_q <= ch_q + 8'd1;
          end
        end
      end
    end
  end

  logic bias_load_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) item_q <= item_i;
    bias_load_q <= cmd_i.start;
    prod_q <= $signed(px_q) * $signed(wt_q);
    if (bias_load_q) acc_q <= AW'($signed(bias_q)) <<< 8;
    else if (prod_valid_q) acc_q <= acc_q + AW'(prod_q);
  end

  // result formatting
  logic signed [AW-1:0] shifted;
  logic bad_q;
  always_ff @(posedge clk_i) if (cmd_i.start) bad_q <= bad;
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (bad_q) begin
        result_o.result_value <= '0;
        result_o.status <= ST_BAD_COORD;
      end else if (shifted > 32767) begin
        result_o.result_value <= 16'sd32767;
        result_o.status <= ST_SATURATED;
      end else if (shifted < -32768) begin
        result_o.result_value <= -16'sd32768;
        result_o.status <= ST_SATURATED;
      end else begin
        result_o.result_value <= shifted[15:0];
        result_o.status <= ST_OK;
      end
    end
  end
  assign shifted = acc_q >>> 8;

  assign sts_o.is_compute = (op_e'(item_i.operation) == OP_COMPUTE);
  assign sts_o.bad_coord  = bad;
  assign sts_o.last_tap   = tap_last;
  assign sts_o.drained    = drained_q;
endmodule

// ----- rtl/c2d_controller.sv -----
// sequencer for loads and the tap loop of a compute transaction
module c2d_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  c2d_pkg::c2d_sts_t sts_i,
  output c2d_pkg::c2d_cmd_t cmd_o
);
  import c2d_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_FIN   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.start = accept;
        if (accept && sts_i.is_compute) state_d = sts_i.bad_coord ? S_FIN : S_RUN;
      end
      S_RUN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_tap) state_d = S_DRAIN;
      end
      S_DRAIN: if (sts_i.drained) state_d = S_FIN;
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
endmodule

// ----- rtl/conv2d_valid_forward_unit.sv -----
// top level of the multichannel stride-1 convolution unit
// channel   dir  payload
// in_s      in   operation, filter/channel/row/col index, load_value
// out_m     out  result_value, status
// apb       in   in_channels, filter count, kernel side, in_height, in_width
// loads are accepted back to back, one per cycle, while the unit is idle
// a compute walks its taps one per cycle through the shared MAC, with read,
//   product, drain and result register stages on the way to the output
// out-of-area computes skip the tap loop and go straight to the finish state
// the result stays in the output register until taken, input waits meanwhile
// reset sets config and control registers, leaves stores and data undefined
module conv2d_valid_forward_unit #(
  parameter int unsigned MAX_IN_CH  = 16,
  parameter int unsigned MAX_OUT_CH = 16,
  parameter int unsigned MAX_KERNEL = 5,
  parameter int unsigned MAX_ROWS   = 32,
  parameter int unsigned MAX_COLS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  c2d_stream_if.sink   in_s,
  c2d_stream_if.source out_m,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import c2d_pkg::*;

  logic [4:0] in_channels_q, filt_count_q;
  logic [2:0] kern_side_q;
  logic [5:0] in_height_q, in_width_q;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_channels_q  <= 5'd1;
      filt_count_q   <= 5'd1;
      kern_side_q    <= 3'd3;
      in_height_q    <= 6'd32;
      in_width_q     <= 6'd32;
    end else if (psel && penable && pwrite) begin
      unique case (32'(paddr[4:2]))
        REG_IN_CHANNELS:  in_channels_q  <= pwdata[4:0];
        REG_FILT_COUNT:   filt_count_q   <= pwdata[4:0];
        REG_KERN_SIDE:    kern_side_q    <= pwdata[2:0];
        REG_IN_HEIGHT:    in_height_q    <= pwdata[5:0];
        REG_IN_WIDTH:     in_width_q     <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (32'(paddr[4:2]))
      REG_IN_CHANNELS:  prdata = {27'd0, in_channels_q};
      REG_FILT_COUNT:   prdata = {27'd0, filt_count_q};
      REG_KERN_SIDE:    prdata = {29'd0, kern_side_q};
      REG_IN_HEIGHT:    prdata = {26'd0, in_height_q};
      REG_IN_WIDTH:     prdata = {26'd0, in_width_q};
      default:          prdata = '0;
    endcase
  end

  c2d_cmd_t cmd;
  c2d_sts_t sts;

  c2d_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_s.valid),
    .in_ready_o (in_s.ready),
    .out_valid_o(out_m.valid),
    .out_ready_i(out_m.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  c2d_datapath #(
    .MAX_IN_CH(MAX_IN_CH), .MAX_OUT_CH(MAX_OUT_CH), .MAX_KERNEL(MAX_KERNEL),
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i          (cmd),
    .sts_o          (sts),
    .item_i         (in_s.data),
    .in_channels_i  (in_channels_q),
    .filt_count_i   (filt_count_q),
    .kern_side_i    (kern_side_q),
    .in_height_i    (in_height_q),
    .in_width_i     (in_width_q),
    .result_o       (out_m.data)
  );
endmodule
